FILE: rtl/sphw_pkg.sv
package sphw_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int SUM_W      = 28;
	localparam int DATA_W     = 16;

	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	typedef struct packed {
		logic load;
		logic init;
		logic side;
		logic issue;
		logic emit;
	} sphw_cmd_t;

	typedef struct packed {
		logic left_skip;
		logic right_skip;
		logic at_end;
	} sphw_stat_t;

endpackage

FILE: rtl/sphw_ctrl.sv
module sphw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  last_sample,
	input  sphw_pkg::sphw_stat_t  stat,
	output sphw_pkg::sphw_cmd_t   cmd,
	output logic                  busy
);

	localparam logic [2:0] S_LOAD   = 3'd0;
	localparam logic [2:0] S_LSETUP = 3'd1;
	localparam logic [2:0] S_LEFT   = 3'd2;
	localparam logic [2:0] S_LDRAIN = 3'd3;
	localparam logic [2:0] S_RSETUP = 3'd4;
	localparam logic [2:0] S_RIGHT  = 3'd5;
	localparam logic [2:0] S_RDRAIN = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign busy   = (state_q != S_LOAD);
	assign accept = start && (state_q == S_LOAD);

	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.init  = (state_q == S_LSETUP) || (state_q == S_RSETUP);
		cmd.side  = (state_q == S_RSETUP) ? sphw_pkg::SIDE_RIGHT : sphw_pkg::SIDE_LEFT;
		cmd.issue = (state_q == S_LEFT) || (state_q == S_RIGHT);
		cmd.emit  = (state_q == S_EMIT);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && last_sample) state_d = S_LSETUP;
			end
			S_LSETUP: begin
				state_d = stat.left_skip ? S_RSETUP : S_LEFT;
			end
			S_LEFT: begin
				if (stat.at_end) state_d = S_LDRAIN;
			end
			S_LDRAIN: state_d = S_RSETUP;
			S_RSETUP: begin
				state_d = stat.right_skip ? S_EMIT : S_RIGHT;
			end
			S_RIGHT: begin
				if (stat.at_end) state_d = S_RDRAIN;
			end
			S_RDRAIN: state_d = S_EMIT;
			S_EMIT:   state_d = S_LOAD;
			default:  state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/sphw_dp.sv
module sphw_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sphw_pkg::sphw_cmd_t                 cmd,
	input  logic [sphw_pkg::DATA_W-1:0]         wavelength,
	input  logic [sphw_pkg::DATA_W-1:0]         energy,
	output sphw_pkg::sphw_stat_t                stat,
	output logic                                done,
	output logic [sphw_pkg::SUM_W-1:0]          energy_sum,
	output logic [sphw_pkg::DATA_W-1:0]         energy_peak,
	output logic [sphw_pkg::DATA_W-1:0]         peak_wavelength,
	output logic [sphw_pkg::DATA_W-1:0]         left_edge,
	output logic [sphw_pkg::DATA_W-1:0]         right_edge,
	output logic [sphw_pkg::DATA_W-1:0]         half_width,
	output logic                                overflowed
);

	localparam int AW = sphw_pkg::ADDR_W;
	localparam int CW = sphw_pkg::CNT_W;
	localparam int DW = sphw_pkg::DATA_W;
	localparam int SW = sphw_pkg::SUM_W;

	logic [DW-1:0] energy_mem [sphw_pkg::MAX_POINTS];
	logic [DW-1:0] wave_mem   [sphw_pkg::MAX_POINTS];

	logic [CW-1:0] count_q;
	logic [DW-1:0] max_q;
	logic [AW-1:0] peak_idx_q;
	logic [DW-1:0] peak_wave_q;
	logic [SW-1:0] sum_q;
	logic          drop_q;

	logic [AW-1:0] addr_q;
	logic          side_q;
	logic [1:0]    issue_n_q;
	logic          rd_v_s1;
	logic          cand_s1;
	logic [DW-1:0] e_rd_s1;
	logic [DW-1:0] w_rd_s1;
	logic [DW-1:0] prev1_q;
	logic [DW-1:0] prev2_q;
	logic          lfound_q;
	logic          rfound_q;
	logic [DW-1:0] ledge_q;
	logic [DW-1:0] redge_q;

	logic [SW-1:0] out_sum_q;
	logic [DW-1:0] out_peak_q;
	logic [DW-1:0] out_pwave_q;
	logic [DW-1:0] out_left_q;
	logic [DW-1:0] out_right_q;
	logic [DW-1:0] out_hw_q;
	logic          out_ovf_q;
	logic          done_q;

	logic          store_ok;
	logic [SW:0]   sum_wide;
	logic [SW-1:0] sum_next;
	logic [AW-1:0] wave_addr;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] peak_p3;
	logic [DW:0]   two_new;
	logic [DW:0]   two_prev2;
	logic [DW:0]   max_ext;
	logic          hit;

	assign store_ok = (count_q < CW'(sphw_pkg::MAX_POINTS));
	assign sum_wide = {1'b0, sum_q} + (SW + 1)'(energy);
	assign sum_next = (sum_wide > {1'b0, sphw_pkg::SUM_LIMIT}) ? sphw_pkg::SUM_LIMIT
	                                                           : sum_wide[SW-1:0];

	// The left search reads the energy one below the candidate, the right search
	// one above, so the wavelength of the candidate sits one address behind.
	assign wave_addr = (side_q == sphw_pkg::SIDE_RIGHT) ? addr_q - AW'(1) : addr_q + AW'(1);

	assign cnt_m1  = count_q - CW'(1);
	assign peak_p3 = {1'b0, peak_idx_q} + CW'(3);

	assign stat.left_skip  = (peak_idx_q < AW'(3));
	assign stat.right_skip = (peak_p3 > count_q);
	assign stat.at_end     = (side_q == sphw_pkg::SIDE_RIGHT) ? (addr_q == cnt_m1[AW-1:0])
	                                                          : (addr_q == AW'(1));

	// Both crossings reduce to the same test: the far neighbor is above half
	// the maximum and the newly read neighbor is below it.
	assign two_new   = {e_rd_s1, 1'b0};
	assign two_prev2 = {prev2_q, 1'b0};
	assign max_ext   = {1'b0, max_q};
	assign hit       = rd_v_s1 && cand_s1 && (two_new < max_ext) && (two_prev2 > max_ext);

	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			energy_mem[count_q[AW-1:0]] <= energy;
			wave_mem[count_q[AW-1:0]]   <= wavelength;
		end
		e_rd_s1 <= energy_mem[addr_q];
		w_rd_s1 <= wave_mem[wave_addr];
		if (rd_v_s1) begin
			prev2_q <= prev1_q;
			prev1_q <= e_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			max_q       <= '0;
			peak_idx_q  <= '0;
			peak_wave_q <= '0;
			sum_q       <= '0;
			drop_q      <= 1'b0;
			addr_q      <= '0;
			side_q      <= sphw_pkg::SIDE_LEFT;
			issue_n_q   <= '0;
			rd_v_s1     <= 1'b0;
			cand_s1     <= 1'b0;
			lfound_q    <= 1'b0;
			rfound_q    <= 1'b0;
			ledge_q     <= '0;
			redge_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.issue;
			cand_s1 <= cmd.issue && (issue_n_q == 2'd2);
			done_q  <= cmd.emit;

			if (cmd.load) begin
				if (store_ok) begin
					sum_q   <= sum_next;
					count_q <= count_q + CW'(1);
					if (energy > max_q) begin
						max_q       <= energy;
						peak_idx_q  <= count_q[AW-1:0];
						peak_wave_q <= wavelength;
					end
				end else begin
					drop_q <= 1'b1;
				end
			end

			if (cmd.init) begin
				addr_q    <= peak_idx_q;
				side_q    <= cmd.side;
				issue_n_q <= '0;
				if (cmd.side == sphw_pkg::SIDE_RIGHT) begin
					rfound_q <= 1'b0;
					redge_q  <= '0;
				end else begin
					lfound_q <= 1'b0;
					ledge_q  <= '0;
				end
			end

			if (cmd.issue) begin
				addr_q <= (side_q == sphw_pkg::SIDE_RIGHT) ? addr_q + AW'(1) : addr_q - AW'(1);
				if (issue_n_q != 2'd2) issue_n_q <= issue_n_q + 2'd1;
			end

			if (hit) begin
				if (side_q == sphw_pkg::SIDE_RIGHT) begin
					if (!rfound_q) begin
						rfound_q <= 1'b1;
						redge_q  <= w_rd_s1;
					end
				end else if (!lfound_q) begin
					lfound_q <= 1'b1;
					ledge_q  <= w_rd_s1;
				end
			end

			if (cmd.emit) begin
				count_q     <= '0;
				max_q       <= '0;
				peak_idx_q  <= '0;
				peak_wave_q <= '0;
				sum_q       <= '0;
				drop_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sum_q   <= sum_q;
			out_peak_q  <= max_q;
			out_pwave_q <= peak_wave_q;
			out_left_q  <= ledge_q;
			out_right_q <= redge_q;
			out_hw_q    <= (ledge_q >= redge_q) ? ledge_q - redge_q : redge_q - ledge_q;
			out_ovf_q   <= drop_q;
		end
	end

	assign done            = done_q;
	assign energy_sum      = out_sum_q;
	assign energy_peak     = out_peak_q;
	assign peak_wavelength = out_pwave_q;
	assign left_edge       = out_left_q;
	assign right_edge      = out_right_q;
	assign half_width      = out_hw_q;
	assign overflowed      = out_ovf_q;

endmodule

FILE: rtl/spectrum_peak_half_width.sv
// A sample without the last mark is absorbed while busy stays low.
// The last sample starts the search: a left walk from the peak index P (skipped
// when P < 3) and a right walk up to the stored count C (skipped when P + 3 > C),
// with setup and output steps around them; done follows the search.
// Throughput: one sample per cycle while loading; busy holds off new samples during the search.
// Reset clears all control and counters; the sample stores are not cleared.
module spectrum_peak_half_width (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [sphw_pkg::DATA_W-1:0]         wavelength,
	input  logic [sphw_pkg::DATA_W-1:0]         energy,
	input  logic                                last_sample,
	output logic                                done,
	output logic [sphw_pkg::SUM_W-1:0]          energy_sum,
	output logic [sphw_pkg::DATA_W-1:0]         energy_peak,
	output logic [sphw_pkg::DATA_W-1:0]         peak_wavelength,
	output logic [sphw_pkg::DATA_W-1:0]         left_edge,
	output logic [sphw_pkg::DATA_W-1:0]         right_edge,
	output logic [sphw_pkg::DATA_W-1:0]         half_width,
	output logic                                overflowed
);

	sphw_pkg::sphw_cmd_t  cmd;
	sphw_pkg::sphw_stat_t stat;

	sphw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_sample (last_sample),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	sphw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.wavelength      (wavelength),
		.energy          (energy),
		.stat            (stat),
		.done            (done),
		.energy_sum      (energy_sum),
		.energy_peak     (energy_peak),
		.peak_wavelength (peak_wavelength),
		.left_edge       (left_edge),
		.right_edge      (right_edge),
		.half_width      (half_width),
		.overflowed      (overflowed)
	);

`ifndef SYNTHESIS
	a_last_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_sample |=> busy)
		else $error("last item did not start the search");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still searching");

	a_width_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (half_width == ((left_edge >= right_edge) ? left_edge - right_edge
		                                                   : right_edge - left_edge)))
		else $error("half width does not match the edges");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.init, cmd.issue, cmd.emit}))
		else $error("controller issued conflicting commands");
`endif

endmodule

FILE: sim/spectrum_peak_half_width_tb.sv
module spectrum_peak_half_width_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W     = sphw_pkg::DATA_W;
	localparam int SUM_W      = sphw_pkg::SUM_W;
	localparam int MAX_POINTS = sphw_pkg::MAX_POINTS;
	localparam logic [SUM_W-1:0] SUM_LIMIT = sphw_pkg::SUM_LIMIT;

	typedef struct {
		logic [DATA_W-1:0] wl;
		logic [DATA_W-1:0] en;
		logic              last;
		int unsigned       gap_pct;
		bit                drain;
	} sample_t;

	typedef struct packed {
		logic [SUM_W-1:0]  total_e;
		logic [DATA_W-1:0] peak;
		logic [DATA_W-1:0] peak_wave;
		logic [DATA_W-1:0] left_wl;
		logic [DATA_W-1:0] right_wl;
		logic [DATA_W-1:0] width;
		logic              ovf;
	} fwhm_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [DATA_W-1:0]   wavelength = '0;
	logic [DATA_W-1:0]   energy = '0;
	logic                last_sample = 1'b0;
	logic                done;
	logic [SUM_W-1:0]    energy_sum;
	logic [DATA_W-1:0]   energy_peak;
	logic [DATA_W-1:0]   peak_wavelength;
	logic [DATA_W-1:0]   left_edge;
	logic [DATA_W-1:0]   right_edge;
	logic [DATA_W-1:0]   half_width;
	logic                overflowed;

	sample_t     sample_queue[$];
	fwhm_t       expected_fwhm[$];
	logic        took = 1'b0;
	int unsigned queued_total = 0;
	int unsigned accepted_total = 0;
	int unsigned errors = 0;
	int unsigned gap_pct = 6;
	bit          drain_next = 1'b0;

	// Our own copy of the spectrum being loaded.
	logic [DATA_W-1:0] wave_mem [MAX_POINTS];
	logic [DATA_W-1:0] energy_mem [MAX_POINTS];
	int unsigned       stored = 0;
	int unsigned       pk_index = 0;
	logic [DATA_W-1:0] pk_energy = '0;
	logic [DATA_W-1:0] pk_wave = '0;
	logic [SUM_W-1:0]  sum_acc = '0;
	logic              dropped = 1'b0;

	logic [DATA_W-1:0] shape [0:4199];
	int unsigned       shape_len = 0;

	spectrum_peak_half_width u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.wavelength     (wavelength),
		.energy         (energy),
		.last_sample    (last_sample),
		.done           (done),
		.energy_sum     (energy_sum),
		.energy_peak    (energy_peak),
		.peak_wavelength(peak_wavelength),
		.left_edge      (left_edge),
		.right_edge     (right_edge),
		.half_width     (half_width),
		.overflowed     (overflowed)
	);

	always #1 clk = ~clk;

	// Walks away from the peak looking for the half-maximum crossing. Energies are
	// doubled instead of halving the peak so the comparison stays exact.
	function automatic logic [DATA_W-1:0] half_max_crossing(input bit rightward);
		logic [DATA_W-1:0] hit;
		bit                found;
		int                i;
		hit = '0;
		found = 1'b0;
		if (!rightward) begin
			if (pk_index >= 3) begin
				for (i = pk_index - 1; i >= 2 && !found; i--) begin
					if ({energy_mem[i-1], 1'b0} < pk_energy &&
							{energy_mem[i+1], 1'b0} > pk_energy) begin
						hit = wave_mem[i];
						found = 1'b1;
					end
				end
			end
		end else begin
			for (i = pk_index + 1; i + 1 < stored && !found; i++) begin
				if ({energy_mem[i-1], 1'b0} > pk_energy &&
						{energy_mem[i+1], 1'b0} < pk_energy) begin
					hit = wave_mem[i];
					found = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	task automatic absorb_sample(input logic [DATA_W-1:0] wl, en, input logic last);
		logic [SUM_W:0] total;
		fwhm_t          r;
		if (stored < MAX_POINTS) begin
			wave_mem[stored] = wl;
			energy_mem[stored] = en;
			total = sum_acc + en;
			sum_acc = (total > SUM_LIMIT) ? SUM_LIMIT : total[SUM_W-1:0];
			if (en > pk_energy) begin
				pk_energy = en;
				pk_index = stored;
				pk_wave = wl;
			end
			stored++;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			r.total_e = sum_acc;
			r.peak = pk_energy;
			r.peak_wave = pk_wave;
			r.left_wl = half_max_crossing(1'b0);
			r.right_wl = half_max_crossing(1'b1);
			r.width = (r.left_wl >= r.right_wl) ? r.left_wl - r.right_wl
				: r.right_wl - r.left_wl;
			r.ovf = dropped;
			expected_fwhm = {expected_fwhm, r};
			stored = 0;
			pk_index = 0;
			pk_energy = '0;
			pk_wave = '0;
			sum_acc = '0;
			dropped = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic queue_sample(input logic [DATA_W-1:0] wl, en, input logic last);
		sample_t s;
		s.wl = wl;
		s.en = en;
		s.last = last;
		s.gap_pct = gap_pct;
		s.drain = drain_next;
		drain_next = 1'b0;
		sample_queue = {sample_queue, s};
		queued_total++;
	endtask

	task automatic put(input int e);
		shape[shape_len] = DATA_W'(e);
		shape_len++;
	endtask

	// Sends the energies collected so far as one spectrum; the last one closes it.
	task automatic queue_shape(input logic [DATA_W-1:0] w0, input int step, input bit rand_wl);
		logic [DATA_W-1:0] wl;
		wl = w0;
		for (int i = 0; i < shape_len; i++) begin
			queue_sample(rand_wl ? DATA_W'($urandom_range(65535)) : wl, shape[i],
				i == shape_len - 1);
			wl = DATA_W'(wl + step);
		end
		shape_len = 0;
	endtask

	// A single peak with noisy ramps on both sides, so that crossings usually exist.
	task automatic build_peak(input int n);
		int p;
		int pk;
		int base;
		p = $urandom_range(n - 1);
		pk = $urandom_range(65535, 1);
		for (int i = 0; i < n; i++) begin
			if (i == p)
				base = pk;
			else if (i < p)
				base = pk * (i + 1) / (p + 1);
			else
				base = pk * (n - i) / (n - p);
			if (i != p)
				base = base - $urandom_range(base / 4);
			put(base);
		end
	endtask

	always @(negedge clk) begin : driver
		sample_t s;
		if (arst_n && (!start || took)) begin
			if (sample_queue.size() != 0
					&& !(sample_queue[0].drain && expected_fwhm.size() != 0)
					&& $urandom_range(99) >= sample_queue[0].gap_pct) begin
				s = sample_queue.pop_front();
				start <= 1'b1;
				wavelength <= s.wl;
				energy <= s.en;
				last_sample <= s.last;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		fwhm_t want;
		took <= arst_n && start && !busy;
		if (arst_n) begin
			// A result is matched before this edge's item is absorbed.
			if (done) begin
				if (expected_fwhm.size() == 0) begin
					$error("result arrived with no spectrum pending");
					errors++;
				end else begin
					want = expected_fwhm.pop_front();
					check_field("energy_sum", want.total_e, energy_sum);
					check_field("energy_peak", want.peak, energy_peak);
					check_field("peak_wavelength", want.peak_wave, peak_wavelength);
					check_field("left_edge", want.left_wl, left_edge);
					check_field("right_edge", want.right_wl, right_edge);
					check_field("half_width", want.width, half_width);
					check_field("overflowed", want.ovf, overflowed);
				end
			end
			if (start && !busy) begin
				absorb_sample(wavelength, energy, last_sample);
				accepted_total++;
			end
		end
	end

	initial begin : stimulus
		int n;
		int kind;
		int rnd_items;
		int step;

		// Lone sample at full scale.
		put(65535);
		queue_shape(16'hFFFF, 0, 1'b0);
		// All energies zero: peak stays at index 0 with wavelength 0.
		put(0); put(0); put(0);
		queue_shape(16'h5555, 16'h5555, 1'b0);
		// Clean peak with both crossings, wavelengths falling so left is above right.
		put(0); put(10); put(40); put(100); put(40); put(10); put(0);
		queue_shape(4000, -1, 1'b0);
		// Peak too close to the start for a left search.
		put(50); put(65535); put(0); put(0);
		queue_shape(100, 7, 1'b0);
		// Two equal maxima: the first one counts.
		put(5); put(9); put(9); put(2);
		queue_shape(9000, -3, 1'b0);
		// Neighbors at exactly half the peak are neither below nor above it.
		put(0); put(50); put(50); put(100); put(50); put(50); put(0);
		queue_shape(60000, 100, 1'b0);

		rnd_items = 0;
		while (rnd_items < 1270) begin
			gap_pct = (rnd_items < 430) ? 6 : (rnd_items < 860) ? 55 : 0;
			if (rnd_items == 0 || $urandom_range(99) < 8)
				drain_next = 1'b1;
			n = ($urandom_range(99) < 5) ? $urandom_range(300, 25) : $urandom_range(24, 1);
			kind = $urandom_range(99);
			if (kind < 70) begin
				build_peak(n);
			end else begin
				for (int i = 0; i < n; i++) begin
					if (kind < 90)
						put($urandom_range(65535));
					else if (kind < 95)
						put(0);
					else
						put($urandom_range(3));
				end
			end
			step = $urandom_range(40, 1);
			if ($urandom_range(1))
				step = -step;
			queue_shape(DATA_W'($urandom_range(65535)), step, $urandom_range(99) < 25);
			rnd_items += n;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_total != queued_total || expected_fwhm.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (errors == 0 && expected_fwhm.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
